// ===== rtl/cic_pkg.sv =====
`default_nettype none
package cic_pkg;

	typedef enum logic [2:0] {
		OP_PORT_WRITE = 3'd0,
		OP_PORT_READ  = 3'd1,
		OP_RAISE      = 3'd2,
		OP_LOWER      = 3'd3,
		OP_DISPATCH   = 3'd4,
		OP_SET_MASK   = 3'd5
	} cic_op_t;

	typedef struct packed {
		logic [2:0] op;
		logic       chip;
		logic       port_select;
		logic [7:0] bus_value;
		logic [3:0] line;
		logic       mask_bit;
		logic       cpu_if;
	} cic_in_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic       int_taken;
		logic [7:0] int_vector;
		logic [3:0] int_line;
		logic       unsupported;
	} cic_out_t;

	localparam logic [15:0] MASK_RESET = 16'hFEF8;
	localparam logic [4:0]  NO_LINE    = 5'd16;

	// Fixed priority order 0,1,2,8..15,3..7.
	function automatic logic [3:0] prio_line(input logic [3:0] k);
		logic [3:0] r;
		begin
			if (k < 4'd3)       r = k;
			else if (k < 4'd11) r = k + 4'd5;
			else                r = k - 4'd8;
			return r;
		end
	endfunction

	function automatic logic [4:0] prio_rank(input logic [4:0] ln);
		logic [4:0] r;
		begin
			if (ln >= 5'd16)     r = 5'd16;
			else if (ln < 5'd3)  r = ln;
			else if (ln < 5'd8)  r = ln + 5'd8;
			else                 r = ln - 5'd5;
			return r;
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/cic_front.sv =====
`default_nettype none
// Accepts transactions and pushes them into a two-entry queue.
module cic_front
	import cic_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire cic_in_t in_data,
	output logic         q_valid,
	input  wire logic    q_pop,
	output cic_in_t      q_data
);
	cic_in_t    mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

// ===== rtl/cic_back.sv =====
`default_nettype none
// Executes one transaction per cycle against the controller state while its output is not stalled.
module cic_back
	import cic_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    q_valid,
	output logic         q_pop,
	input  wire cic_in_t q_data,
	output logic         out_valid,
	input  wire logic    out_stall,
	output cic_out_t     out_data
);
	logic [15:0] req_q, msk_q, isr_q;
	logic [4:0]  vb_q [2];
	logic [4:0]  cur_q;
	logic [1:0]  step_q [2], words_q [2];
	logic [1:0]  single_q, aeoi_q, rot_q, risr_q, smm_q;
	logic        ov_q;
	cic_out_t    od_q;

	logic        go;
	cic_in_t     d;
	cic_out_t    r;
	logic [15:0] req_n, msk_n, isr_n;
	logic [4:0]  cur_n;
	logic [4:0]  vb_n [2];
	logic [1:0]  step_n [2], words_n [2];
	logic [1:0]  single_n, aeoi_n, rot_n, risr_n, smm_n;
	logic        c;
	logic [7:0]  v;
	logic [3:0]  base;
	logic [4:0]  rank, eoi_cur;
	logic [15:0] isr_eoi;
	logic        eoi_do, fnd;
	logic [3:0]  sel;
	logic [3:0]  ln;

	assign go        = q_valid && (!ov_q || !out_stall);
	assign q_pop     = go;
	assign out_valid = ov_q;
	assign out_data  = od_q;

	always_comb begin
		d = q_data;
		c = d.chip;
		v = d.bus_value;
		base = {c, 3'b000};
		req_n = req_q; msk_n = msk_q; isr_n = isr_q; cur_n = cur_q;
		vb_n = vb_q; step_n = step_q; words_n = words_q;
		single_n = single_q; aeoi_n = aeoi_q; rot_n = rot_q;
		risr_n = risr_q; smm_n = smm_q;
		r = '0;
		eoi_do = 1'b0;
		sel = 4'd0; fnd = 1'b0;
		// end-of-interrupt rescan
		isr_eoi = isr_q;
		if (cur_q < 5'd16) isr_eoi[cur_q[3:0]] = 1'b0;
		eoi_cur = NO_LINE;
		for (int k = 15; k >= 0; k--) begin
			ln = prio_line(4'(k));
			if (isr_eoi[ln]) eoi_cur = {1'b0, ln};
		end
		rank = prio_rank(cur_q);
		case (d.op)
			OP_PORT_WRITE: begin
				if (!d.port_select) begin
					if (v[4]) begin
						if ((v & 8'hEC) != 8'd0) r.unsupported = 1'b1;
						else begin
							single_n[c] = v[1];
							step_n[c] = 2'd1;
							words_n[c] = 2'd2 + {1'b0, v[0]};
						end
					end else if (v[3]) begin
						if (v[2]) r.unsupported = 1'b1;
						else begin
							if (v[1]) risr_n[c] = v[0];
							if (v[6]) smm_n[c] = v[5];
						end
					end else if (v[5]) begin
						if (v[7]) r.unsupported = 1'b1;
						else if (v[6]) eoi_do = (cur_q == {1'b0, base} + {2'b0, v[2:0]});
						else eoi_do = (cur_q < {1'b0, base} + 5'd8);
					end else if (!v[6]) rot_n[c] = v[7];
				end else begin
					case (step_q[c])
						2'd0: begin
							if (c) msk_n[15:8] = v; else msk_n[7:0] = v;
						end
						2'd1: begin
							vb_n[c] = v[7:3];
							if (step_q[c] >= words_q[c]) step_n[c] = 2'd0;
							else if (single_q[c]) step_n[c] = 2'd3;
							else step_n[c] = 2'd2;
						end
						2'd2: step_n[c] = (step_q[c] >= words_q[c]) ? 2'd0 : 2'd3;
						default: begin
							if (!v[0]) r.unsupported = 1'b1;
							else begin
								aeoi_n[c] = v[1];
								step_n[c] = (step_q[c] >= words_q[c]) ? 2'd0 : 2'd0;
							end
						end
					endcase
				end
			end
			OP_PORT_READ: begin
				if (d.port_select) r.read_value = c ? msk_q[15:8] : msk_q[7:0];
				else if (risr_q[c]) r.read_value = c ? isr_q[15:8] : isr_q[7:0];
				else begin
					r.read_value = c ? req_q[15:8] : req_q[7:0];
					if (!c && !msk_q[2] && ((req_q & ~msk_q & 16'hFF00) != 16'd0))
						r.read_value[2] = 1'b1;
				end
			end
			OP_RAISE: req_n[d.line] = 1'b1;
			OP_LOWER: req_n[d.line] = 1'b0;
			OP_SET_MASK: msk_n[d.line] = d.mask_bit;
			OP_DISPATCH: begin
				if (d.cpu_if) begin
					for (int k = 15; k >= 0; k--) begin
						ln = prio_line(4'(k));
						if (((5'(k) < rank) || smm_q[ln[3]]) && !msk_q[ln] && req_q[ln]
						    && !(ln[3] && msk_q[2])) begin
							fnd = 1'b1; sel = ln;
						end
					end
					if (fnd) begin
						if (aeoi_q[sel[3]] && rot_q[sel[3]]) r.unsupported = 1'b1;
						else begin
							req_n[sel] = 1'b0;
							r.int_taken = 1'b1;
							r.int_vector = {vb_q[sel[3]], sel[2:0]};
							r.int_line = sel;
							if (!aeoi_q[sel[3]]) begin
								cur_n = {1'b0, sel};
								isr_n[sel] = 1'b1;
							end
						end
					end
				end
			end
			default: ;
		endcase
		if (eoi_do) begin
			isr_n = isr_eoi;
			cur_n = eoi_cur;
		end
	end

	always_ff @(posedge clk) begin
		if (go) od_q <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= '0; msk_q <= MASK_RESET; isr_q <= '0; cur_q <= NO_LINE;
			vb_q[0] <= 5'd1; vb_q[1] <= 5'd14;
			step_q[0] <= '0; step_q[1] <= '0; words_q[0] <= '0; words_q[1] <= '0;
			single_q <= '0; aeoi_q <= '0; rot_q <= '0; risr_q <= '0; smm_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (go) begin
				req_q <= req_n; msk_q <= msk_n; isr_q <= isr_n; cur_q <= cur_n;
				vb_q <= vb_n; step_q <= step_n; words_q <= words_n;
				single_q <= single_n; aeoi_q <= aeoi_n; rot_q <= rot_n;
				risr_q <= risr_n; smm_q <= smm_n;
			end
			if (go) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/cascaded_interrupt_controller_core.sv =====
`default_nettype none
// Cascaded master/slave interrupt controller pair. Each transaction on the
// input channel (port write, port read, line raise or lower, mask set, or a
// dispatch attempt) yields exactly one result transaction. A front stage
// queues up to two transactions; the back stage executes one per cycle, with
// the sixteen-line priority scan and the end-of-interrupt rescan done in that
// single cycle, and holds the result in an output register. A result passes
// through the queue entry and then the output register, and the sustained
// rate is one transaction per cycle while the output is not stalled.
module cascaded_interrupt_controller_core
	import cic_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire cic_in_t in_data,
	output logic         out_valid,
	input  wire logic    out_stall,
	output cic_out_t     out_data
);
	logic    q_valid, q_pop;
	cic_in_t q_data;

	cic_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.q_valid, .q_pop, .q_data
	);

	cic_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_data,
		.out_valid, .out_stall, .out_data
	);
endmodule
`default_nettype wire

// ===== rtl/cic_checker.sv =====
`default_nettype none
module cic_checker
	import cic_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_valid,
	input wire logic     in_stall,
	input wire logic     out_valid,
	input wire logic     out_stall,
	input wire cic_out_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_taken_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.int_taken |-> out_data.int_vector[2:0] == out_data.int_line[2:0])
		else $error("vector does not match line");
	a_taken_uns: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.int_taken |-> !out_data.unsupported)
		else $error("taken with unsupported flag");
	// The queue only fills while a stalled result is waiting at the output.
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |-> out_valid)
		else $error("input stalled with no result waiting");
endmodule

bind cascaded_interrupt_controller_core cic_checker u_cic_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
`default_nettype wire
